/* hdl/nbw_pkg.sv */
// shared types, constants and helpers for the neighbor edge weight block
`timescale 1ns / 1ps
`default_nettype none
package nbw_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = COL_W + 1;

    localparam int IMG_W     = 12;
    localparam int BETA_W    = 32;
    localparam int GAMMA_W   = 16;
    localparam int PIX_W     = 24;
    localparam int WT_W      = 24;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_SCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_GAIN  = 2'd2;

    localparam logic [IMG_W-1:0]   RST_IMAGE_WIDTH = 12'd640;
    localparam logic [BETA_W-1:0]  RST_BETA_SCALE  = 32'd268435;
    localparam logic [GAMMA_W-1:0] RST_GAMMA_GAIN  = 16'd12800;

    localparam logic [30:0] ONE_Q30       = 31'h4000_0000;
    localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;
    localparam logic [3:0]  EXP_TERMS     = 4'd12;

    // neighbor select codes
    localparam logic [1:0] NB_LEFT    = 2'd0;
    localparam logic [1:0] NB_UPLEFT  = 2'd1;
    localparam logic [1:0] NB_UP      = 2'd2;
    localparam logic [1:0] NB_UPRIGHT = 2'd3;

    // datapath operation codes
    localparam logic [3:0] OP_NONE = 4'd0;
    localparam logic [3:0] OP_LOAD = 4'd1;
    localparam logic [3:0] OP_DIST = 4'd2;
    localparam logic [3:0] OP_BETA = 4'd3;
    localparam logic [3:0] OP_H1   = 4'd4;
    localparam logic [3:0] OP_H2   = 4'd5;
    localparam logic [3:0] OP_H3   = 4'd6;
    localparam logic [3:0] OP_SQ1  = 4'd7;
    localparam logic [3:0] OP_SQ2  = 4'd8;
    localparam logic [3:0] OP_GAIN = 4'd9;
    localparam logic [3:0] OP_DIAG = 4'd10;
    localparam logic [3:0] OP_SAVE = 4'd11;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_start;
    } in_beat_t;

    typedef struct packed {
        logic [WT_W-1:0] weight_left;
        logic [WT_W-1:0] weight_upleft;
        logic [WT_W-1:0] weight_up;
        logic [WT_W-1:0] weight_upright;
    } out_beat_t;

    typedef struct packed {
        logic       accept;
        logic [3:0] op;
        logic [1:0] nsel;
        logic [3:0] k;
        logic       push;
    } nbw_cmd_t;

    // floor(2^32 / k) for k = 2..12, k = 1 handled by bypass
    function automatic logic [31:0] recip_q32(input logic [3:0] k);
        logic [31:0] m;
        begin
            case (k)
                4'd2:    m = 32'd2147483648;
                4'd3:    m = 32'd1431655765;
                4'd4:    m = 32'd1073741824;
                4'd5:    m = 32'd858993459;
                4'd6:    m = 32'd715827882;
                4'd7:    m = 32'd613566756;
                4'd8:    m = 32'd536870912;
                4'd9:    m = 32'd477218588;
                4'd10:   m = 32'd429496729;
                4'd11:   m = 32'd390451572;
                4'd12:   m = 32'd357913941;
                default: m = 32'd0;
            endcase
            return m;
        end
    endfunction

endpackage
`default_nettype wire

/* hdl/neighbor_edge_weights.sv */
// top level of the neighbor edge weight block
//
// in channel: one raster pixel per beat (blue, green, red, frame_start),
// taken when in_valid is high and in_stall is low. frame_start marks row 0,
// column 0 of a new image.
// out channel: one beat per pixel with four Q8.16 weights toward the left,
// up-left, up and up-right neighbors, zero where the neighbor is off image.
// cfg port: image_width, beta_scale, gamma_gain written by index; the user
// writes them only while idle, the block itself does not enforce it.
// one pixel is worked at a time, from accept to the next accept: the
// shared exp unit runs 12 Horner steps and 4 squarings for each of the four
// neighbors, plus distance, gain and scaling steps. the result shows on
// out_valid when the next pixel can be taken.
// the result sits in an output register, so a stalled receiver holds the beat
// while the next pixel is already being worked; a new result waits until the
// register frees.
// reset: registers return to 640 / 268435 / 12800, the first pixel is taken
// as row 0 column 0, the line store is not cleared (no clearing pass).
`timescale 1ns / 1ps
`default_nettype none
module neighbor_edge_weights
    import nbw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_beat_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_beat_t                 out_data,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    nbw_cmd_t cmd;
    logic     out_free;

    // sequencer steps the datapath through each neighbor in turn
    nbw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_free (out_free),
        .cmd      (cmd)
    );

    nbw_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

/* hdl/nbw_ctrl.sv */
// sequencer for the neighbor edge weight datapath
`timescale 1ns / 1ps
`default_nettype none
module nbw_ctrl
    import nbw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire logic     out_free,
    output nbw_cmd_t      cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_LOAD = 4'd1;
    localparam logic [3:0] ST_DIST = 4'd2;
    localparam logic [3:0] ST_BETA = 4'd3;
    localparam logic [3:0] ST_H1   = 4'd4;
    localparam logic [3:0] ST_H2   = 4'd5;
    localparam logic [3:0] ST_H3   = 4'd6;
    localparam logic [3:0] ST_SQ1  = 4'd7;
    localparam logic [3:0] ST_SQ2  = 4'd8;
    localparam logic [3:0] ST_GAIN = 4'd9;
    localparam logic [3:0] ST_DIAG = 4'd10;
    localparam logic [3:0] ST_SAVE = 4'd11;
    localparam logic [3:0] ST_DONE = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [1:0] nsel_reg, nsel_next;
    logic [3:0] k_reg, k_next;
    logic [1:0] sq_reg, sq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nsel_reg  <= NB_LEFT;
            k_reg     <= EXP_TERMS;
            sq_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            nsel_reg  <= nsel_next;
            k_reg     <= k_next;
            sq_reg    <= sq_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        nsel_next  = nsel_reg;
        k_next     = k_reg;
        sq_next    = sq_reg;
        cmd.accept = 1'b0;
        cmd.op     = OP_NONE;
        cmd.nsel   = nsel_reg;
        cmd.k      = k_reg;
        cmd.push   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.op     = OP_LOAD;
                nsel_next  = NB_LEFT;
                state_next = ST_DIST;
            end
            ST_DIST:
            begin
                cmd.op     = OP_DIST;
                state_next = ST_BETA;
            end
            ST_BETA:
            begin
                cmd.op     = OP_BETA;
                k_next     = EXP_TERMS;
                state_next = ST_H1;
            end
            ST_H1:
            begin
                cmd.op     = OP_H1;
                state_next = ST_H2;
            end
            ST_H2:
            begin
                cmd.op     = OP_H2;
                state_next = ST_H3;
            end
            ST_H3:
            begin
                cmd.op = OP_H3;
                if (k_reg == 4'd1)
                begin
                    sq_next    = 2'd0;
                    state_next = ST_SQ1;
                end
                else
                begin
                    k_next     = k_reg - 4'd1;
                    state_next = ST_H1;
                end
            end
            ST_SQ1:
            begin
                cmd.op     = OP_SQ1;
                state_next = ST_SQ2;
            end
            ST_SQ2:
            begin
                cmd.op = OP_SQ2;
                if (sq_reg == 2'd3)
                begin
                    state_next = ST_GAIN;
                end
                else
                begin
                    sq_next    = sq_reg + 2'd1;
                    state_next = ST_SQ1;
                end
            end
            ST_GAIN:
            begin
                cmd.op = OP_GAIN;
                if (nsel_reg == NB_UPLEFT || nsel_reg == NB_UPRIGHT)
                begin
                    state_next = ST_DIAG;
                end
                else
                begin
                    state_next = ST_SAVE;
                end
            end
            ST_DIAG:
            begin
                cmd.op     = OP_DIAG;
                state_next = ST_SAVE;
            end
            ST_SAVE:
            begin
                cmd.op = OP_SAVE;
                if (nsel_reg == NB_UPRIGHT)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    nsel_next  = nsel_reg + 2'd1;
                    state_next = ST_DIST;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hdl/nbw_dp.sv */
// datapath: line store, neighbor registers, shared exp unit and output register
`timescale 1ns / 1ps
`default_nettype none
module nbw_dp
    import nbw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire nbw_cmd_t             cmd,
    input  wire in_beat_t             in_data,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output logic                      out_free,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_beat_t                 out_data
);

    // configuration and frame position
    logic [IMG_W-1:0]   image_width_reg;
    logic [BETA_W-1:0]  beta_scale_reg;
    logic [GAMMA_W-1:0] gamma_gain_reg;
    logic [COL_W-1:0]   column_count_reg, column_count_next;
    logic               first_row_reg, first_row_next;
    logic [PIX_W-1:0]   left_pixel_reg, upleft_pixel_reg;
    logic               out_valid_reg;

    // per pixel payload
    logic [PIX_W-1:0]   cur_reg;
    logic [COL_W-1:0]   x_reg, x_next;
    logic [3:0]         en_reg, en_next;
    logic [PIX_W-1:0]   nb_reg [4];
    logic [PIX_W-1:0]   rd_up_reg, rd_ur_reg;
    logic [PIX_W-1:0]   mem [MAX_WIDTH];

    // exp unit
    logic [17:0]        d_reg;
    logic [31:0]        g_reg;
    logic               zero_reg;
    logic [30:0]        r_reg;
    logic [62:0]        prod_reg;
    logic [29:0]        t_reg;
    logic [61:0]        mq_reg;
    logic [46:0]        gw_reg;
    logic [62:0]        dw_reg;
    logic [WT_W-1:0]    wt_reg [4];
    out_beat_t          out_data_reg;

    logic [WID_W-1:0]   w_eff;
    logic [COL_W-1:0]   cc_a;
    logic               fr_a;
    logic [WID_W-1:0]   x1_a;
    logic [COL_W-1:0]   rd_addr_up, rd_addr_ur;

    // clamp width to 2..MAX_WIDTH
    always_comb
    begin
        if (image_width_reg < IMG_W'(2))
        begin
            w_eff = WID_W'(2);
        end
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WID_W'(image_width_reg);
        end
    end

    // column tracking for the beat being accepted
    always_comb
    begin
        cc_a = in_data.frame_start ? '0 : column_count_reg;
        fr_a = in_data.frame_start ? 1'b1 : first_row_reg;
        if ({1'b0, cc_a} >= w_eff)
        begin
            cc_a = '0;
            fr_a = 1'b0;
        end
        x_next = cc_a;
        x1_a   = {1'b0, cc_a} + WID_W'(1);
        if (x1_a >= w_eff)
        begin
            column_count_next = '0;
            first_row_next    = 1'b0;
        end
        else
        begin
            column_count_next = x1_a[COL_W-1:0];
            first_row_next    = fr_a;
        end
        en_next[NB_LEFT]    = (cc_a != '0);
        en_next[NB_UPLEFT]  = !fr_a && (cc_a != '0);
        en_next[NB_UP]      = !fr_a;
        en_next[NB_UPRIGHT] = !fr_a && (x1_a < w_eff);
        rd_addr_up = cc_a;
        rd_addr_ur = x1_a[COL_W-1:0];
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            beta_scale_reg   <= RST_BETA_SCALE;
            gamma_gain_reg   <= RST_GAMMA_GAIN;
            column_count_reg <= '0;
            first_row_reg    <= 1'b1;
            left_pixel_reg   <= '0;
            upleft_pixel_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH: image_width_reg <= cfg_data[IMG_W-1:0];
                    CFG_BETA_SCALE:  beta_scale_reg  <= cfg_data[BETA_W-1:0];
                    CFG_GAMMA_GAIN:  gamma_gain_reg  <= cfg_data[GAMMA_W-1:0];
                    default:         image_width_reg <= image_width_reg;
                endcase
            end
            if (cmd.accept)
            begin
                column_count_reg <= column_count_next;
                first_row_reg    <= first_row_next;
            end
            if (cmd.op == OP_LOAD)
            begin
                left_pixel_reg   <= cur_reg;
                upleft_pixel_reg <= rd_up_reg;
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // line store, read at x and x+1 on accept, written in the load cycle
    always_ff @(posedge clk)
    begin
        rd_up_reg <= mem[rd_addr_up];
        rd_ur_reg <= mem[rd_addr_ur];
        if (cmd.op == OP_LOAD)
        begin
            mem[x_reg] <= cur_reg;
        end
    end

    logic [7:0]  db, dg, dr;
    logic [17:0] sq_sum;
    logic [PIX_W-1:0] nb_sel;
    logic [49:0] p_full;
    logic [29:0] q0, q;
    logic [33:0] q0k, rem;

    always_comb
    begin
        nb_sel = nb_reg[cmd.nsel];
        db = (cur_reg[7:0] > nb_sel[7:0]) ? cur_reg[7:0] - nb_sel[7:0]
                                           : nb_sel[7:0] - cur_reg[7:0];
        dg = (cur_reg[15:8] > nb_sel[15:8]) ? cur_reg[15:8] - nb_sel[15:8]
                                             : nb_sel[15:8] - cur_reg[15:8];
        dr = (cur_reg[23:16] > nb_sel[23:16]) ? cur_reg[23:16] - nb_sel[23:16]
                                               : nb_sel[23:16] - cur_reg[23:16];
        sq_sum = (18'(db) * 18'(db)) + (18'(dg) * 18'(dg)) + (18'(dr) * 18'(dr));
        p_full = beta_scale_reg * d_reg;
        // quotient by reciprocal, at most one short
        q0  = (cmd.k == 4'd1) ? t_reg : mq_reg[61:32];
        q0k = 34'(q0) * 34'(cmd.k);
        rem = {4'b0, t_reg} - q0k;
        q   = (rem >= 34'(cmd.k)) ? q0 + 30'd1 : q0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cur_reg <= {in_data.red, in_data.green, in_data.blue};
            x_reg   <= x_next;
            en_reg  <= en_next;
        end
        case (cmd.op)
            OP_LOAD:
            begin
                nb_reg[NB_LEFT]    <= left_pixel_reg;
                nb_reg[NB_UPLEFT]  <= upleft_pixel_reg;
                nb_reg[NB_UP]      <= rd_up_reg;
                nb_reg[NB_UPRIGHT] <= rd_ur_reg;
            end
            OP_DIST: d_reg <= sq_sum;
            OP_BETA:
            begin
                g_reg    <= p_full[31:0];
                zero_reg <= (p_full[49:32] != '0);
                r_reg    <= ONE_Q30;
            end
            OP_H1: prod_reg <= 63'(g_reg * r_reg);
            OP_H2:
            begin
                t_reg  <= prod_reg[61:32];
                mq_reg <= prod_reg[61:32] * recip_q32(cmd.k);
            end
            OP_H3:  r_reg    <= ONE_Q30 - 31'(q);
            OP_SQ1: prod_reg <= 63'(r_reg * r_reg);
            OP_SQ2: r_reg    <= prod_reg[60:30];
            OP_GAIN: gw_reg  <= gamma_gain_reg * (zero_reg ? 31'd0 : r_reg);
            OP_DIAG: dw_reg  <= 63'(gw_reg * INV_SQRT2_Q16);
            OP_SAVE:
            begin
                if (!en_reg[cmd.nsel])
                begin
                    wt_reg[cmd.nsel] <= '0;
                end
                else if (cmd.nsel == NB_UPLEFT || cmd.nsel == NB_UPRIGHT)
                begin
                    wt_reg[cmd.nsel] <= dw_reg[61:38];
                end
                else
                begin
                    wt_reg[cmd.nsel] <= gw_reg[45:22];
                end
            end
            default: d_reg <= d_reg;
        endcase
        if (cmd.push)
        begin
            out_data_reg.weight_left    <= wt_reg[NB_LEFT];
            out_data_reg.weight_upleft  <= wt_reg[NB_UPLEFT];
            out_data_reg.weight_up      <= wt_reg[NB_UP];
            out_data_reg.weight_upright <= wt_reg[NB_UPRIGHT];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

/* hdl/nbw_chk.sv */
// port level checks for the neighbor edge weight block
`timescale 1ns / 1ps
`default_nettype none
module nbw_chk
    import nbw_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_stall,
    input wire in_beat_t             in_data,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire out_beat_t            out_data
);

    // a stalled pixel beat stays put
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("in beat changed under stall");

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out beat dropped under stall");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("out beat changed under stall");

    // one pixel at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a pixel is in work");

    // a new result only comes out of a busy block
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no pixel in work");

endmodule

bind neighbor_edge_weights nbw_chk u_nbw_chk (.*);
`default_nettype wire

/* dv/nbw_checker.sv */
// checker for the neighbor edge weight block: predicts weights per pixel and compares beats
`timescale 1ns / 1ps
`default_nettype none
module nbw_checker
    import nbw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire in_beat_t             in_data,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire out_beat_t            out_data,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output int                        fail_count,
    output int                        pending
);

    logic [IMG_W-1:0]   width_reg;
    logic [BETA_W-1:0]  beta_reg;
    logic [GAMMA_W-1:0] gamma_reg;
    logic [PIX_W-1:0]   line_mem [MAX_WIDTH];
    logic [PIX_W-1:0]   left_px;
    logic [PIX_W-1:0]   upleft_px;
    int                 col;
    bit                 top_row;
    out_beat_t          weight_queue [$];

    function automatic longint unsigned sq_dist(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
        longint unsigned sum;
        int d;
        sum = 0;
        for (int c = 0; c < 3; c++)
        begin
            d = int'(a[8*c +: 8]) - int'(b[8*c +: 8]);
            sum += longint'(d * d);
        end
        return sum;
    endfunction

    // exp(-beta*d) in Q2.30
    function automatic longint unsigned decay_q30(longint unsigned d);
        longint unsigned arg;
        longint unsigned r;
        arg = longint'(beta_reg) * d;
        if (arg >= 64'h1_0000_0000)
            return 0;
        r = 64'd1 << 30;
        for (int k = 12; k >= 1; k--)
            r = (64'd1 << 30) - (((arg * r) >> 32) / k);
        for (int i = 0; i < 4; i++)
            r = (r * r) >> 30;
        return r;
    endfunction

    function automatic logic [WT_W-1:0] edge_wt(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                                bit diag);
        longint unsigned w;
        w = longint'(gamma_reg) * decay_q30(sq_dist(a, b));
        if (diag)
            return WT_W'((w * 46341) >> 38);
        return WT_W'(w >> 22);
    endfunction

    assign pending = weight_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        int w;
        int x;
        logic [PIX_W-1:0] cur;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] upright;
        out_beat_t exp_beat;
        out_beat_t got;
        if (!rst_n)
        begin
            width_reg  <= RST_IMAGE_WIDTH;
            beta_reg   <= RST_BETA_SCALE;
            gamma_reg  <= RST_GAMMA_GAIN;
            left_px    <= '0;
            upleft_px  <= '0;
            col        = 0;
            top_row    = 1'b1;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH: width_reg <= cfg_data[IMG_W-1:0];
                    CFG_BETA_SCALE:  beta_reg  <= cfg_data[BETA_W-1:0];
                    CFG_GAMMA_GAIN:  gamma_reg <= cfg_data[GAMMA_W-1:0];
                    default: ;
                endcase
            end
            // predict from the accepted pixel using blocking locals
            if (in_valid && !in_stall)
            begin
                w = width_reg;
                if (w < 2) w = 2;
                if (w > MAX_WIDTH) w = MAX_WIDTH;
                cur = {in_data.red, in_data.green, in_data.blue};
                x = col;
                if (in_data.frame_start)
                begin
                    x = 0;
                    top_row = 1'b1;
                end
                if (x >= w)
                begin
                    x = 0;
                    top_row = 1'b0;
                end
                up = line_mem[x];
                upright = (x + 1 < w) ? line_mem[x + 1] : '0;
                exp_beat = '0;
                if (x > 0) exp_beat.weight_left = edge_wt(cur, left_px, 0);
                if (!top_row)
                begin
                    exp_beat.weight_up = edge_wt(cur, up, 0);
                    if (x > 0) exp_beat.weight_upleft = edge_wt(cur, upleft_px, 1);
                    if (x + 1 < w) exp_beat.weight_upright = edge_wt(cur, upright, 1);
                end
                weight_queue.insert(weight_queue.size(), exp_beat);
                upleft_px <= up;
                left_px   <= cur;
                line_mem[x] = cur;
                if (x + 1 >= w)
                begin
                    col = 0;
                    top_row = 1'b0;
                end
                else
                    col = x + 1;
            end
            if (out_valid && !out_stall)
            begin
                got = out_data;
                if (weight_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected weight beat %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_beat = weight_queue.pop_front();
                    if (got !== exp_beat)
                    begin
                        if (fail_count < 10)
                            $display({"weight mismatch: exp l=%h ul=%h u=%h ur=%h ",
                                      "got l=%h ul=%h u=%h ur=%h"},
                                exp_beat.weight_left, exp_beat.weight_upleft,
                                exp_beat.weight_up, exp_beat.weight_upright,
                                got.weight_left, got.weight_upleft,
                                got.weight_up, got.weight_upright);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

/* dv/tb_neighbor_edge_weights.sv */
// top of the neighbor edge weight testbench: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_neighbor_edge_weights;
    import nbw_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_beat_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_beat_t            out_data;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;
    int                   fail_count;
    int                   pending;

    // idle chances in percent for each side
    int                   send_idle = 16;
    int                   recv_idle = 46;
    int                   quiet_cycles;
    // watchdog limit: a pixel's work stretched by stalls, with margin
    localparam int        STUCK_LIMIT = 20000;

    // widest row in force; this bench never assigns it
    int                   row_len;

    always #4 clk = ~clk;

    neighbor_edge_weights i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nbw_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver stalls at random
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STUCK_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // one pixel beat, sender gap first; valid stays high between beats with no gap
    task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fs);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{blue: b, green: g, red: r, frame_start: fs};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // full frame of random pixels; smooth rows keep pixel distances small
    task automatic send_frame(int rows, int width, bit smooth);
        logic [7:0] base;
        base = 8'($urandom);
        for (int y = 0; y < rows; y++)
            for (int x = 0; x < width; x++)
            begin
                if (smooth)
                    send_pixel(base + 8'($urandom_range(3)), base + 8'($urandom_range(3)),
                               base ^ 8'($urandom_range(1)), (x == 0 && y == 0));
                else
                    send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                               (x == 0 && y == 0));
            end
    endtask

    initial
    begin
        int n;
        int w;
        int rows;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset width 640, two rows cut short by frame starts are avoided;
        // use a small width so second rows are fully written
        write_reg(CFG_IMAGE_WIDTH, 32'd3);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'h01, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
        send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
        drain();
        // extremes of gain and beta
        write_reg(CFG_BETA_SCALE, 32'd0);
        write_reg(CFG_GAMMA_GAIN, 32'hFFFF);
        send_frame(2, 3, 0);
        drain();
        write_reg(CFG_BETA_SCALE, 32'hFFFF_FFFF);
        write_reg(CFG_GAMMA_GAIN, 32'd0);
        send_frame(2, 3, 1);
        drain();
        // width below minimum acts as 2, then shrink mid-row
        write_reg(CFG_IMAGE_WIDTH, 32'd0);
        write_reg(CFG_GAMMA_GAIN, 32'd12800);
        write_reg(CFG_BETA_SCALE, 32'd268435);
        send_frame(2, 2, 1);
        drain();
        write_reg(CFG_IMAGE_WIDTH, 32'd4);
        send_frame(1, 3, 1);
        drain();
        write_reg(CFG_IMAGE_WIDTH, 32'd2);
        send_pixel(8'h10, 8'h20, 8'h30, 1'b0);
        send_pixel(8'h11, 8'h21, 8'h31, 1'b0);
        drain();

        // random phases over pacing modes; width changes only between frames
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 16 : (phase == 1) ? 46 : 0;
            recv_idle = (phase == 0) ? 46 : (phase == 1) ? 16 : 0;
            n = 0;
            while (n < 256)
            begin
                w = ($urandom_range(9) == 0) ? $urandom_range(2, 64) : $urandom_range(2, 8);
                write_reg(CFG_IMAGE_WIDTH, 32'(w));
                case ($urandom_range(3))
                    0: write_reg(CFG_BETA_SCALE, $urandom);
                    1: write_reg(CFG_BETA_SCALE, $urandom_range(2000000));
                    default: write_reg(CFG_BETA_SCALE, $urandom_range(300000));
                endcase
                write_reg(CFG_GAMMA_GAIN, $urandom_range(65535));
                rows = (w > 16) ? 2 : $urandom_range(2, 5);
                send_frame(rows, w, 1'($urandom_range(1)));
                n += w * rows;
                drain();
            end
        end
        // two pixels at the widest width, the largest register value clamped
        write_reg(CFG_IMAGE_WIDTH, 32'hFFF);
        send_pixel(8'h00, 8'hFF, 8'h80, 1'b1);
        send_pixel(8'hFF, 8'h00, 8'h7F, 1'b0);
        drain();

        repeat (400) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire

/* neighbor_edge_weights.f */
hdl/nbw_pkg.sv
hdl/nbw_ctrl.sv
hdl/nbw_dp.sv
hdl/neighbor_edge_weights.sv
hdl/nbw_chk.sv
dv/nbw_checker.sv
dv/tb_neighbor_edge_weights.sv
